// File: rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int MAX_WORDS        = 1024;
  localparam int ADDR_W           = $clog2(MAX_WORDS);
  localparam int SIZE_W           = ADDR_W + 1;
  localparam int MAX_BLOCK        = 32;
  localparam int STG_DEPTH        = 32;
  localparam int STG_AW           = $clog2(STG_DEPTH);
  localparam int CNT_W            = 6;
  localparam int INITIAL_WORDS    = 8;
  localparam int MIN_SHRINK_WORDS = 16;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_PRINT = 2'd2;
  localparam logic [1:0] OP_USAGE = 2'd3;

  localparam logic [2:0] KIND_ADDR  = 3'd0;
  localparam logic [2:0] KIND_WORD  = 3'd1;
  localparam logic [2:0] KIND_EMPTY = 3'd2;
  localparam logic [2:0] KIND_USAGE = 3'd3;
  localparam logic [2:0] KIND_FAIL  = 3'd4;

endpackage

// File: rtl/ffba_ram.sv
module ffba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/first_fit_block_allocator.sv
// Channel   Dir  Handshake                       Content
// s_axis    in   s_axis_tvalid / s_axis_tready   one request: op, data word, last, address
// m_axis    out  m_axis_tvalid / m_axis_tready   one result: kind, word, address, usage, size
//
// After reset a clearing pass writes zero to all 1024 store words;
// no request is taken during it.
// Alloc and usage scan the store at one word per cycle; alloc then writes the header
// and data words one per cycle. Free clears its words one per cycle and scans from
// size/4 for the shrink check. Print reads, registers and emits each word in turn.
// Results wait in an output register, and a stalled output holds the engine only
// when the next result is ready.
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // word_value[31:0], address[41:32], zero
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // data_word[31:0], start_address[41:32],
                                      // used_count[52:42], logical_size[63:53]
  output logic [2:0]  m_axis_tuser,   // kind[2:0]
  output logic        m_axis_tlast
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ASCAN = 4'd2;
  localparam logic [3:0] S_AHDR  = 4'd3;
  localparam logic [3:0] S_ADAT  = 4'd4;
  localparam logic [3:0] S_FHDR  = 4'd5;
  localparam logic [3:0] S_FCLR  = 4'd6;
  localparam logic [3:0] S_FSHR  = 4'd7;
  localparam logic [3:0] S_USCAN = 4'd8;
  localparam logic [3:0] S_PHDR  = 4'd9;
  localparam logic [3:0] S_PRD   = 4'd10;
  localparam logic [3:0] S_PDAT  = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0]        state;
  logic [3:0]        ret_state;
  logic [SIZE_W-1:0] cur_size;
  logic [SIZE_W-1:0] s_size;
  logic [CNT_W-1:0]  stg_count;
  logic [SIZE_W-1:0] iss_idx;
  logic              p_valid;
  logic [SIZE_W-1:0] p_idx;
  logic [CNT_W-1:0]  run;
  logic [CNT_W-1:0]  need;
  logic [CNT_W-1:0]  n_len;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] start;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] end_r;
  logic [SIZE_W-1:0] clr_idx;
  logic [SIZE_W-1:0] used;
  logic [63:0]       res_data;
  logic [2:0]        res_kind;
  logic              res_last;

  logic [ADDR_W-1:0] in_addr;
  logic [31:0]       in_word;
  logic              accept;
  logic              issue;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [31:0]       mem_q;
  logic              stg_we;
  logic [STG_AW-1:0] stg_raddr;
  logic [31:0]       stg_q;
  logic              q_zero;
  logic [CNT_W-1:0]  n_new;
  logic [32:0]       f_sum;
  logic [CNT_W-1:0]  p_cnt;
  logic [SIZE_W-1:0] p_room;
  logic [SIZE_W-1:0] p_take;

  function automatic logic [63:0] pack_res(logic [31:0] w, logic [ADDR_W-1:0] a,
                                           logic [SIZE_W-1:0] u, logic [SIZE_W-1:0] s);
    return {s, u, a, w};
  endfunction

  assign in_word       = s_axis_tdata[31:0];
  assign in_addr       = s_axis_tdata[41:32];
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_zero        = (mem_q == 32'd0);
  assign stg_we        = accept && (s_axis_tuser == OP_ALLOC) &&
                         (stg_count < CNT_W'(MAX_BLOCK));
  assign n_new         = (stg_count < CNT_W'(MAX_BLOCK)) ? stg_count + 1'b1
                                                         : CNT_W'(MAX_BLOCK + 1);
  assign f_sum         = {1'b0, mem_q} + 33'(addr_r);
  assign p_cnt         = mem_q[31] ? '0 :
                         ((mem_q > 32'(MAX_BLOCK)) ? CNT_W'(MAX_BLOCK) : mem_q[CNT_W-1:0]);
  assign p_room        = cur_size - 1'b1 - SIZE_W'(addr_r);
  assign p_take        = (SIZE_W'(p_cnt) > p_room) ? p_room : SIZE_W'(p_cnt);

  always_comb begin
    issue = 1'b0;
    unique case (state)
      S_ASCAN:         issue = !iss_idx[ADDR_W];
      S_FSHR, S_USCAN: issue = (iss_idx < cur_size);
      default:         issue = 1'b0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx[ADDR_W-1:0];
    mem_wdata = '0;
    mem_raddr = iss_idx[ADDR_W-1:0];
    stg_raddr = '0;
    unique case (state)
      S_CLR:  mem_we = 1'b1;
      S_IDLE: mem_raddr = in_addr;
      S_AHDR: begin
        mem_we    = 1'b1;
        mem_waddr = start;
        mem_wdata = 32'(n_len);
      end
      S_ADAT: begin
        mem_we    = (cnt != n_len);
        mem_waddr = start + 1'b1 + ADDR_W'(cnt);
        mem_wdata = stg_q;
        stg_raddr = STG_AW'(cnt + 1'b1);
      end
      S_FCLR: mem_we = 1'b1;
      S_PRD:  mem_raddr = addr_r + 1'b1 + ADDR_W'(cnt);
      default: begin
      end
    endcase
  end

  ffba_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  ffba_ram #(.WIDTH(32), .DEPTH(STG_DEPTH)) u_staging (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_count[STG_AW-1:0]),
    .wdata (in_word),
    .raddr (stg_raddr),
    .rdata (stg_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      ret_state     <= S_IDLE;
      cur_size      <= SIZE_W'(INITIAL_WORDS);
      stg_count     <= '0;
      clr_idx       <= '0;
      iss_idx       <= '0;
      p_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      p_valid <= issue;
      p_idx   <= iss_idx;
      if (issue) begin
        iss_idx <= iss_idx + 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready && (state != S_EMIT)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SIZE_W'(MAX_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            addr_r <= in_addr;
            unique case (s_axis_tuser)
              OP_ALLOC: begin
                stg_count <= s_axis_tlast ? '0 : n_new;
                if (s_axis_tlast) begin
                  if (n_new > CNT_W'(MAX_BLOCK)) begin
                    res_kind  <= KIND_FAIL;
                    res_data  <= '0;
                    res_last  <= 1'b1;
                    ret_state <= S_IDLE;
                    state     <= S_EMIT;
                  end else begin
                    n_len   <= n_new;
                    need    <= n_new + 1'b1;
                    s_size  <= cur_size;
                    run     <= '0;
                    iss_idx <= '0;
                    state   <= S_ASCAN;
                  end
                end
              end
              OP_FREE: begin
                if (SIZE_W'(in_addr) < cur_size) begin
                  state <= S_FHDR;
                end
              end
              OP_PRINT: begin
                if (SIZE_W'(in_addr) < cur_size) begin
                  state <= S_PHDR;
                end else begin
                  res_kind  <= KIND_EMPTY;
                  res_data  <= '0;
                  res_last  <= 1'b1;
                  ret_state <= S_IDLE;
                  state     <= S_EMIT;
                end
              end
              OP_USAGE: begin
                used    <= '0;
                iss_idx <= '0;
                state   <= S_USCAN;
              end
            endcase
          end
        end

        S_ASCAN: begin
          if (p_valid) begin
            if (q_zero && (run + 1'b1 == need)) begin
              start    <= (run == '0) ? p_idx[ADDR_W-1:0] : start;
              cur_size <= s_size;
              state    <= S_AHDR;
            end else begin
              if (q_zero) begin
                if (run == '0) begin
                  start <= p_idx[ADDR_W-1:0];
                end
                run <= run + 1'b1;
              end else begin
                run <= '0;
              end
              if (p_idx + 1'b1 == s_size) begin
                if (s_size <= SIZE_W'(MAX_WORDS / 2)) begin
                  s_size <= {s_size[SIZE_W-2:0], 1'b0};
                end else begin
                  res_kind  <= KIND_FAIL;
                  res_data  <= '0;
                  res_last  <= 1'b1;
                  ret_state <= S_IDLE;
                  state     <= S_EMIT;
                end
              end
            end
          end
        end

        S_AHDR: begin
          cnt   <= '0;
          state <= S_ADAT;
        end

        S_ADAT: begin
          if (cnt == n_len) begin
            res_kind  <= KIND_ADDR;
            res_data  <= pack_res('0, start, '0, '0);
            res_last  <= 1'b1;
            ret_state <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_FHDR: begin
          if (!mem_q[31]) begin
            clr_idx <= SIZE_W'(addr_r);
            end_r   <= (f_sum >= 33'(cur_size)) ? ADDR_W'(cur_size - 1'b1)
                                                 : f_sum[ADDR_W-1:0];
            state   <= S_FCLR;
          end else begin
            iss_idx <= cur_size >> 2;
            state   <= S_FSHR;
          end
        end

        S_FCLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx[ADDR_W-1:0] == end_r) begin
            iss_idx <= cur_size >> 2;
            state   <= S_FSHR;
          end
        end

        S_FSHR: begin
          if (p_valid) begin
            if (!q_zero) begin
              state <= S_IDLE;
            end else if (p_idx + 1'b1 == cur_size) begin
              if (cur_size >= SIZE_W'(MIN_SHRINK_WORDS)) begin
                cur_size <= cur_size >> 1;
              end
              state <= S_IDLE;
            end
          end
        end

        S_USCAN: begin
          if (p_valid) begin
            used <= used + SIZE_W'(!q_zero);
            if (p_idx + 1'b1 == cur_size) begin
              res_kind  <= KIND_USAGE;
              res_data  <= pack_res('0, '0, used + SIZE_W'(!q_zero), cur_size);
              res_last  <= 1'b1;
              ret_state <= S_IDLE;
              state     <= S_EMIT;
            end
          end
        end

        S_PHDR: begin
          if (p_take == '0) begin
            res_kind  <= KIND_EMPTY;
            res_data  <= '0;
            res_last  <= 1'b1;
            ret_state <= S_IDLE;
            state     <= S_EMIT;
          end else begin
            n_len <= CNT_W'(p_take);
            cnt   <= '0;
            state <= S_PRD;
          end
        end

        S_PRD: state <= S_PDAT;

        S_PDAT: begin
          res_kind  <= KIND_WORD;
          res_data  <= pack_res(mem_q, '0, '0, '0);
          res_last  <= (cnt + 1'b1 == n_len);
          ret_state <= (cnt + 1'b1 == n_len) ? S_IDLE : S_PRD;
          cnt       <= cnt + 1'b1;
          state     <= S_EMIT;
        end

        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_data;
            m_axis_tuser  <= res_kind;
            m_axis_tlast  <= res_last;
            state         <= ret_state;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
